// ----- rtl/ckmer_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckmer_pkg
// types, constants and helper functions shared by the canonical k-mer encoder
// ----------------------------------------------------------------------------
package ckmer_pkg;

  localparam int unsigned MaxKmer  = 32;
  localparam int unsigned MinKmer  = 4;
  localparam int unsigned KLenW    = 6;
  localparam int unsigned KmerW    = 2 * MaxKmer;
  localparam logic [KLenW-1:0] KLenReset = KLenW'(MaxKmer);

  // ascii codes of the accepted bases
  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChUpC = 8'h43;
  localparam logic [7:0] ChUpG = 8'h47;
  localparam logic [7:0] ChUpT = 8'h54;
  localparam logic [7:0] ChLoA = 8'h61;
  localparam logic [7:0] ChLoC = 8'h63;
  localparam logic [7:0] ChLoG = 8'h67;
  localparam logic [7:0] ChLoT = 8'h74;

  typedef enum logic [1:0] {
    BASE_A = 2'd0,
    BASE_C = 2'd1,
    BASE_G = 2'd2,
    BASE_T = 2'd3
  } base_e;

  typedef struct packed {
    logic [7:0] base_char;
    logic       seq_start;
  } in_item_t;

  typedef struct packed {
    logic             kmer_valid;
    logic [KmerW-1:0] canonical_kmer;
    logic             from_reverse;
  } out_item_t;

  typedef struct packed {
    logic valid;
    base_e code;
  } base_dec_t;

  // control from the top level into the window
  typedef struct packed {
    logic advance;
    logic clear;
  } win_ctrl_t;

  // next window contents handed to the selector
  typedef struct packed {
    logic             kmer_valid;
    logic [KmerW-1:0] fwd;
    logic [KmerW-1:0] rev;
  } win_out_t;

  function automatic base_dec_t base_decode(input logic [7:0] ch);
    base_dec_t d;
    d.valid = 1'b1;
    d.code  = BASE_A;
    unique case (ch)
      ChUpA, ChLoA: d.code = BASE_A;
      ChUpC, ChLoC: d.code = BASE_C;
      ChUpG, ChLoG: d.code = BASE_G;
      ChUpT, ChLoT: d.code = BASE_T;
      default:      d.valid = 1'b0;
    endcase
    return d;
  endfunction

  // clamp the programmed length into the supported range
  function automatic logic [KLenW-1:0] eff_k(input logic [KLenW-1:0] len);
    logic [KLenW-1:0] k;
    k = len;
    if (k < KLenW'(MinKmer)) begin
      k = KLenW'(MinKmer);
    end
    if (k > KLenW'(MaxKmer)) begin
      k = KLenW'(MaxKmer);
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ckmer_window.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckmer_window
// forward and reverse-complement base windows with the valid-run counter
// ----------------------------------------------------------------------------
module ckmer_window (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ckmer_pkg::win_ctrl_t         ctrl_i,
  input  wire ckmer_pkg::in_item_t          item_i,
  input  wire logic [ckmer_pkg::KLenW-1:0]  k_i,
  output      ckmer_pkg::win_out_t          win_o
);

  logic [ckmer_pkg::KmerW-1:0] fwd_q, fwd_d, fwd_base, fwd_sh;
  logic [ckmer_pkg::KmerW-1:0] rev_q, rev_d, rev_base, rev_sh;
  logic [ckmer_pkg::KLenW-1:0] run_q, run_d, run_base, k_m1;
  ckmer_pkg::base_dec_t        dec;

  always_comb begin
    dec      = ckmer_pkg::base_decode(item_i.base_char);
    fwd_base = item_i.seq_start ? '0 : fwd_q;
    rev_base = item_i.seq_start ? '0 : rev_q;
    run_base = item_i.seq_start ? '0 : run_q;
    k_m1     = k_i - ckmer_pkg::KLenW'(1);
    fwd_sh   = {fwd_base[ckmer_pkg::KmerW-3:0], dec.code};
    rev_sh   = {2'b00, rev_base[ckmer_pkg::KmerW-1:2]};
    fwd_d    = '0;
    rev_d    = '0;
    // lanes at or above k stay zero
    for (int i = 0; i < ckmer_pkg::MaxKmer; i++) begin
      if (ckmer_pkg::KLenW'(i) < k_i) begin
        fwd_d[2*i +: 2] = fwd_sh[2*i +: 2];
        rev_d[2*i +: 2] = rev_sh[2*i +: 2]
                          | ((ckmer_pkg::KLenW'(i) == k_m1) ? ~dec.code : 2'b00);
      end
    end
    run_d = (run_base < k_i) ? run_base + ckmer_pkg::KLenW'(1) : run_base;
    if (!dec.valid) begin
      fwd_d = '0;
      rev_d = '0;
      run_d = '0;
    end
    win_o.kmer_valid = dec.valid && (run_d >= k_i);
    win_o.fwd        = fwd_d;
    win_o.rev        = rev_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= '0;
      rev_q <= '0;
      run_q <= '0;
    end else if (ctrl_i.clear) begin
      fwd_q <= '0;
      rev_q <= '0;
      run_q <= '0;
    end else if (ctrl_i.advance) begin
      fwd_q <= fwd_d;
      rev_q <= rev_d;
      run_q <= run_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ckmer_select.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckmer_select
// picks the smaller strand as the canonical k-mer
// ----------------------------------------------------------------------------
module ckmer_select (
  input  wire ckmer_pkg::win_out_t  win_i,
  output      ckmer_pkg::out_item_t res_o
);

  logic rev_lt;

  always_comb begin
    rev_lt = win_i.rev < win_i.fwd;
    res_o  = '0;
    if (win_i.kmer_valid) begin
      res_o.kmer_valid     = 1'b1;
      res_o.from_reverse   = rev_lt;
      // palindromes keep the forward strand
      res_o.canonical_kmer = rev_lt ? win_i.rev : win_i.fwd;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/canonical_kmer_encoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// canonical_kmer_encoder_top
// streams ascii bases into 2-bit k-mer windows and emits the canonical k-mer
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  in_item_i  (base_char, seq_start)
//   out      output     out_valid_o / out_stall_i out_item_o (kmer_valid, kmer, strand)
//   cfg      input      cfg_we_i                 cfg_wdata_i (kmer_length)
//
// one item per cycle sustained while the output is not stalled; each accepted item
// sits in the input register, then the window update and strand
// compare run combinationally into the result register
// a stalled result holds the pipeline; the input register still takes an item
// while the result waits, so the input stalls only when both stages are full
// reset clears the windows, the run count and both stage valids; k resets to 32
// a length write clears the windows and the run count
//
module canonical_kmer_encoder_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire ckmer_pkg::in_item_t          in_item_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      ckmer_pkg::out_item_t         out_item_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [ckmer_pkg::KLenW-1:0]  cfg_wdata_i
);

  // configuration
  logic [ckmer_pkg::KLenW-1:0] klen_q;
  logic [ckmer_pkg::KLenW-1:0] k_eff;

  // input stage
  logic                 in_vld_q;
  ckmer_pkg::in_item_t  in_q;

  // result stage
  logic                 out_vld_q;
  ckmer_pkg::out_item_t out_q;
  ckmer_pkg::out_item_t res;

  ckmer_pkg::win_ctrl_t ctrl;
  ckmer_pkg::win_out_t  win;
  logic                 advance;
  logic                 in_take;

  assign k_eff = ckmer_pkg::eff_k(klen_q);

  // the held item moves on when the result register is free or being drained
  assign advance   = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign ctrl.advance = advance;
  assign ctrl.clear   = cfg_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= ckmer_pkg::KLenReset;
    end else if (cfg_we_i) begin
      klen_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
  end

  ckmer_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .item_i (in_q),
    .k_i    (k_eff),
    .win_o  (win)
  );

  ckmer_select u_select (
    .win_i (win),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  // a strand flag only comes with a full k-mer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.from_reverse |-> out_q.kmer_valid)
    else $error("strand flag set without a valid k-mer");

  // no partial k-mer leaks out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.kmer_valid |-> (out_q.canonical_kmer == '0))
    else $error("k-mer bits set on an invalid result");

  // the input stalls only while both stages are full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // a held result does not change while the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(out_q))
    else $error("stalled result dropped or changed");
`endif

endmodule
`default_nettype wire
